@@ sv/qsed_pkg.sv @@
// ----------------------------------------------------------------------------
// qsed_pkg
// Shared codes, character constants and decode helpers for the quoted
// string escape decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package qsed_pkg;

  // decoder modes
  localparam logic [3:0] M_IDLE     = 4'd0;
  localparam logic [3:0] M_STR      = 4'd1;
  localparam logic [3:0] M_ESC      = 4'd2;
  localparam logic [3:0] M_OCT1     = 4'd3;
  localparam logic [3:0] M_OCT2     = 4'd4;
  localparam logic [3:0] M_HEX0     = 4'd5;
  localparam logic [3:0] M_HEX1     = 4'd6;
  localparam logic [3:0] M_AFTER_LF = 4'd7;
  localparam logic [3:0] M_AFTER_CR = 4'd8;

  // result kinds
  localparam logic [1:0] K_BYTE   = 2'd0;
  localparam logic [1:0] K_CLOSE  = 2'd1;
  localparam logic [1:0] K_BADESC = 2'd2;
  localparam logic [1:0] K_NOEND  = 2'd3;

  // characters
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_DQUOT = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_X     = 8'h78;

  typedef struct packed {
    logic       hit;
    logic [7:0] val;
  } esc_lookup_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] val;
  } hex_lookup_t;

  // simple escape letter to byte
  function automatic esc_lookup_t simple_esc(input logic [7:0] c);
    esc_lookup_t r;
    r.hit = 1'b1;
    r.val = 8'h00;
    unique case (c)
      8'h62:   r.val = 8'h08;  // b
      8'h74:   r.val = 8'h09;  // t
      8'h76:   r.val = 8'h0B;  // v
      8'h6E:   r.val = 8'h0A;  // n
      8'h66:   r.val = 8'h0C;  // f
      8'h72:   r.val = 8'h0D;  // r
      8'h22:   r.val = 8'h22;  // double quote
      8'h27:   r.val = 8'h27;  // single quote
      8'h5C:   r.val = 8'h5C;  // backslash
      default: r.hit = 1'b0;
    endcase
    return r;
  endfunction

  // hex digit value in either case
  function automatic hex_lookup_t hex_digit(input logic [7:0] c);
    hex_lookup_t r;
    r.hit = 1'b1;
    r.val = 4'h0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.val = c[3:0];
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      r.val = 4'(c[2:0] + 3'd1) + 4'd8;
    end else begin
      r.hit = 1'b0;
    end
    return r;
  endfunction

  function automatic logic is_oct(input logic [7:0] c);
    return (c[7:3] == 5'b00110);
  endfunction

endpackage

`default_nettype wire

@@ sv/quoted_string_escape_decoder.sv @@
// ----------------------------------------------------------------------------
// quoted_string_escape_decoder
// Decodes C style quoted strings from a byte stream, one byte per cycle unless stalled.
// ----------------------------------------------------------------------------
//  channel | ports                                 | direction
//  input   | in_valid, in_stall, in_byte[7:0]      | bytes in
//  result  | out_valid, out_stall, out_byte[7:0],  | decoded bytes and
//          | out_kind[1:0]                         | end / error reports
//
//  one byte per cycle while the result register is not stalled; an accepted
//  byte is held in the input register, then decoded into the result register
//  bytes that cause no result still pass both stages and update the mode
//  rst_n is synchronous; mode returns to idle and both stages empty
//  in_stall rises only when the input register holds a byte and the result
//  register is full and stalled
// ----------------------------------------------------------------------------
`default_nettype none

module quoted_string_escape_decoder (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic [1:0]      out_kind
);

  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic [3:0] mode_r, mode_nxt;
  logic [7:0] esc_r, esc_nxt;
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic [1:0] out_kind_r;

  logic       out_free;
  logic       proc_en;
  logic       in_take;

  logic       res_vld;
  logic [1:0] res_kind;
  logic [7:0] res_byte;
  logic       str_like;

  qsed_pkg::esc_lookup_t simple;
  qsed_pkg::hex_lookup_t hex;

  // handshake
  assign out_free = !out_valid_r || !out_stall;
  assign proc_en  = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_kind  = out_kind_r;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
    if (in_take) begin
      s1_byte_r <= in_byte;
    end
  end

  assign simple = qsed_pkg::simple_esc(s1_byte_r);
  assign hex    = qsed_pkg::hex_digit(s1_byte_r);

  // byte handled as string body: in a string, or after a line splice that
  // is not followed by its partner character
  assign str_like = (mode_r == qsed_pkg::M_STR) ||
                    (mode_r == qsed_pkg::M_AFTER_LF && s1_byte_r != qsed_pkg::CH_CR) ||
                    (mode_r == qsed_pkg::M_AFTER_CR && s1_byte_r != qsed_pkg::CH_LF);

  // decode
  always_comb begin
    res_vld  = 1'b0;
    res_kind = qsed_pkg::K_BYTE;
    res_byte = 8'h00;
    mode_nxt = mode_r;
    esc_nxt  = esc_r;
    if (str_like) begin
      if (s1_byte_r == qsed_pkg::CH_NUL) begin
        res_vld  = 1'b1;
        res_kind = qsed_pkg::K_NOEND;
        mode_nxt = qsed_pkg::M_IDLE;
      end else if (s1_byte_r == qsed_pkg::CH_DQUOT) begin
        res_vld  = 1'b1;
        res_kind = qsed_pkg::K_CLOSE;
        mode_nxt = qsed_pkg::M_IDLE;
      end else if (s1_byte_r == qsed_pkg::CH_BSL) begin
        mode_nxt = qsed_pkg::M_ESC;
      end else begin
        res_vld  = 1'b1;
        res_byte = s1_byte_r;
        mode_nxt = qsed_pkg::M_STR;
      end
    end else begin
      unique case (mode_r)
        qsed_pkg::M_AFTER_LF, qsed_pkg::M_AFTER_CR: begin
          // swallowed partner of a line splice
          mode_nxt = qsed_pkg::M_STR;
        end
        qsed_pkg::M_ESC: begin
          priority if (s1_byte_r == qsed_pkg::CH_NUL) begin
            res_vld  = 1'b1;
            res_kind = qsed_pkg::K_NOEND;
            mode_nxt = qsed_pkg::M_IDLE;
          end else if (simple.hit) begin
            res_vld  = 1'b1;
            res_byte = simple.val;
            mode_nxt = qsed_pkg::M_STR;
          end else if (qsed_pkg::is_oct(s1_byte_r)) begin
            esc_nxt  = {5'd0, s1_byte_r[2:0]};
            mode_nxt = qsed_pkg::M_OCT1;
          end else if (s1_byte_r == qsed_pkg::CH_X) begin
            mode_nxt = qsed_pkg::M_HEX0;
          end else if (s1_byte_r == qsed_pkg::CH_LF) begin
            res_vld  = 1'b1;
            res_byte = qsed_pkg::CH_LF;
            mode_nxt = qsed_pkg::M_AFTER_LF;
          end else if (s1_byte_r == qsed_pkg::CH_CR) begin
            res_vld  = 1'b1;
            res_byte = qsed_pkg::CH_LF;
            mode_nxt = qsed_pkg::M_AFTER_CR;
          end else begin
            res_vld  = 1'b1;
            res_kind = qsed_pkg::K_BADESC;
            mode_nxt = qsed_pkg::M_IDLE;
          end
        end
        qsed_pkg::M_OCT1, qsed_pkg::M_OCT2: begin
          priority if (s1_byte_r == qsed_pkg::CH_NUL) begin
            res_vld  = 1'b1;
            res_kind = qsed_pkg::K_NOEND;
            mode_nxt = qsed_pkg::M_IDLE;
          end else if (!qsed_pkg::is_oct(s1_byte_r)) begin
            res_vld  = 1'b1;
            res_kind = qsed_pkg::K_BADESC;
            mode_nxt = qsed_pkg::M_IDLE;
          end else begin
            // low 8 bits of the octal value
            esc_nxt = {esc_r[4:0], s1_byte_r[2:0]};
            if (mode_r == qsed_pkg::M_OCT1) begin
              mode_nxt = qsed_pkg::M_OCT2;
            end else begin
              res_vld  = 1'b1;
              res_byte = {esc_r[4:0], s1_byte_r[2:0]};
              mode_nxt = qsed_pkg::M_STR;
            end
          end
        end
        qsed_pkg::M_HEX0, qsed_pkg::M_HEX1: begin
          priority if (s1_byte_r == qsed_pkg::CH_NUL) begin
            res_vld  = 1'b1;
            res_kind = qsed_pkg::K_NOEND;
            mode_nxt = qsed_pkg::M_IDLE;
          end else if (!hex.hit) begin
            res_vld  = 1'b1;
            res_kind = qsed_pkg::K_BADESC;
            mode_nxt = qsed_pkg::M_IDLE;
          end else if (mode_r == qsed_pkg::M_HEX0) begin
            esc_nxt  = {4'd0, hex.val};
            mode_nxt = qsed_pkg::M_HEX1;
          end else begin
            esc_nxt  = {esc_r[3:0], hex.val};
            res_vld  = 1'b1;
            res_byte = {esc_r[3:0], hex.val};
            mode_nxt = qsed_pkg::M_STR;
          end
        end
        default: begin
          // idle and unused codes: wait for the opening quote
          mode_nxt = (s1_byte_r == qsed_pkg::CH_DQUOT) ? qsed_pkg::M_STR
                                                       : qsed_pkg::M_IDLE;
        end
      endcase
    end
  end

  // decoder state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= qsed_pkg::M_IDLE;
      esc_r  <= 8'h00;
    end else if (proc_en) begin
      mode_r <= mode_nxt;
      esc_r  <= esc_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= proc_en && res_vld;
    end
    if (proc_en && res_vld) begin
      out_byte_r <= res_byte;
      out_kind_r <= res_kind;
    end
  end

endmodule

`default_nettype wire

@@ sv/qsed_checker.sv @@
// ----------------------------------------------------------------------------
// qsed_checker
// Port level checks for the quoted string escape decoder.
// ----------------------------------------------------------------------------
`default_nettype none

module qsed_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic [7:0] in_byte,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] out_byte,
  input wire logic [1:0] out_kind
);

  // stalled input item holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_byte))
    else $error("stalled input item changed");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_kind))
    else $error("stalled result changed");

  // only decoded bytes carry data
  a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != qsed_pkg::K_BYTE |-> out_byte == 8'h00)
    else $error("non-byte result with nonzero data");

  // a fresh result comes from an item taken into the input register and then decoded
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result without a matching item");

  // reset empties the result register
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind quoted_string_escape_decoder qsed_checker u_qsed_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_byte   (in_byte),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_byte  (out_byte),
  .out_kind  (out_kind)
);

`default_nettype wire
